/* hdl/mhpq_pkg.sv */
// Shared types, sizes and codes for the min-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TOTAL_W  = 7;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam int OUT_TOP_LSB    = 0;
    localparam int OUT_CNT_LSB    = 32;
    localparam int OUT_EMPTY_BIT  = 39;
    localparam int OUT_STATUS_LSB = 40;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                       push;
        logic                       pop;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

    typedef struct packed {
        logic                       valid;
        logic                       lt;
        logic signed [VALUE_W-1:0]  value;
    } cell_link_t;

endpackage

/* hdl/mhpq_cell.sv */
// One slot of the sorted cell row: holds an entry and trades it with its neighbors.
module mhpq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mhpq_pkg::cell_cmd_t  cmd,
    input  mhpq_pkg::cell_link_t left_in,
    input  mhpq_pkg::cell_link_t right_in,
    output mhpq_pkg::cell_link_t link
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [mhpq_pkg::VALUE_W-1:0] value_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] value_next;
    logic                               lt;

    assign lt = !valid_reg || (cmd.value < value_reg);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.push)
        begin
            valid_next = valid_reg | left_in.valid;
            if (lt)
            begin
                value_next = left_in.lt ? left_in.value : cmd.value;
            end
        end
        else if (cmd.pop)
        begin
            valid_next = right_in.valid;
            value_next = right_in.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.lt    = lt;
    assign link.value = value_reg;

endmodule

/* hdl/min_heap_priority_queue_unit.sv */
// Top level of the min-heap priority queue: cell row, entry count and result register.
//
// Priority queue of up to CAPACITY signed 32-bit values, kept as a row of cells sorted
// from the smallest entry upward. A push (tuser 0) compares its value against every cell
// at once and each cell either holds, takes its left neighbor, or takes the new value;
// a pop (tuser 1) shifts the row down by one. The cell row is updated as each item is
// accepted and its result beat is registered; a new item is taken in the same cycle
// that the pending result is taken, so one item per cycle is sustained when the output
// side is ready. Every result reports the minimum (0 when empty), the entry count, an
// empty flag and a status: push while full and pop while empty leave the contents
// unchanged and are flagged. No clearing pass is needed after reset.
module min_heap_priority_queue_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mhpq_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  logic                           s_tuser,  // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata   // [31:0] top_value, [38:32] entry_total,
                                                      // [39] is_empty, [41:40] status
);

    localparam int N = mhpq_pkg::CAPACITY;

    mhpq_pkg::cell_cmd_t                 cmd;
    mhpq_pkg::cell_link_t                links [N];
    mhpq_pkg::cell_link_t                head;
    mhpq_pkg::cell_link_t                tail;

    logic [mhpq_pkg::CNT_W-1:0]          count_reg;
    logic [mhpq_pkg::CNT_W-1:0]          count_next;
    logic                                accept;
    logic                                full;
    logic                                empty;
    logic signed [mhpq_pkg::VALUE_W-1:0] in_value;

    logic                                out_valid_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] top_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] top_next;
    logic [mhpq_pkg::TOTAL_W-1:0]        total_reg;
    logic                                empty_reg;
    mhpq_pkg::status_t                   status_reg;
    mhpq_pkg::status_t                   status_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_value = s_tdata[mhpq_pkg::VALUE_W-1:0];
    assign full     = (count_reg == mhpq_pkg::CNT_W'(N));
    assign empty    = (count_reg == '0);

    assign cmd.push  = accept && (s_tuser == mhpq_pkg::KIND_PUSH) && !full;
    assign cmd.pop   = accept && (s_tuser == mhpq_pkg::KIND_POP) && !empty;
    assign cmd.value = in_value;

    assign head.valid = 1'b1;
    assign head.lt    = 1'b0;
    assign head.value = in_value;

    assign tail.valid = 1'b0;
    assign tail.lt    = 1'b0;
    assign tail.value = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        mhpq_pkg::cell_link_t left_link;
        mhpq_pkg::cell_link_t right_link;

        if (i == 0)
        begin : g_first
            assign left_link = head;
        end
        else
        begin : g_mid_left
            assign left_link = links[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign right_link = tail;
        end
        else
        begin : g_mid_right
            assign right_link = links[i+1];
        end

        mhpq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .left_in  (left_link),
            .right_in (right_link),
            .link     (links[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        top_next    = links[0].value;
        status_next = mhpq_pkg::ST_OK;
        if (cmd.push)
        begin
            count_next = count_reg + mhpq_pkg::CNT_W'(1);
            if (links[0].lt)
            begin
                top_next = in_value;
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - mhpq_pkg::CNT_W'(1);
            top_next   = links[1].value;
        end
        else if (accept && (s_tuser == mhpq_pkg::KIND_PUSH))
        begin
            status_next = mhpq_pkg::ST_FULL;
        end
        else if (accept)
        begin
            status_next = mhpq_pkg::ST_EMPTY;
        end
        if (count_next == '0)
        begin
            top_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg    <= top_next;
            total_reg  <= mhpq_pkg::TOTAL_W'(count_next);
            empty_reg  <= (count_next == '0);
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, status_reg, empty_reg, total_reg, top_reg};

endmodule

/* hdl/mhpq_checker.sv */
// Port-level assertions for the min-heap priority queue, bound to the top level.
module mhpq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [mhpq_pkg::VALUE_W-1:0] top_value;
    logic [mhpq_pkg::TOTAL_W-1:0] entry_total;
    logic                         is_empty;
    logic [1:0]                   status;

    assign top_value   = m_tdata[mhpq_pkg::OUT_TOP_LSB +: mhpq_pkg::VALUE_W];
    assign entry_total = m_tdata[mhpq_pkg::OUT_CNT_LSB +: mhpq_pkg::TOTAL_W];
    assign is_empty    = m_tdata[mhpq_pkg::OUT_EMPTY_BIT];
    assign status      = m_tdata[mhpq_pkg::OUT_STATUS_LSB +: 2];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (is_empty == (entry_total == '0)) && (!is_empty || top_value == '0))
        else $error("empty flag, count and top value disagree");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == mhpq_pkg::ST_FULL)
        |-> entry_total == mhpq_pkg::TOTAL_W'(mhpq_pkg::CAPACITY))
        else $error("push rejected while not full");

    a_pop_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == mhpq_pkg::ST_EMPTY) |-> is_empty)
        else $error("pop flagged empty on a non-empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid ##1 m_tvalid && (status == mhpq_pkg::ST_OK)
        |-> (entry_total == $past(entry_total) + 1'b1)
            || (entry_total == $past(entry_total) - 1'b1))
        else $error("entry count did not move by one on an accepted operation");

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (.*);
